// ===== hw/rtl/bfdp_pkg.sv =====
// shared types, constants and codes for the bounded timestamp fifo
// no dependencies
package bfdp_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TIME_W    = 32;
  localparam int SIZE_W    = 11;
  localparam int OCC_W     = 11;
  localparam int LIM_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = SIZE_W'(1024);

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_POLICY = 1'd0,
    CFG_MAX_SIZE    = 1'd1
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic    rd;        // read head entry into the ram output register
    logic    capture;   // latch the request time
    logic    exec;      // apply the operation and load the result
    logic    push;
    logic    pop;
    logic    clr;
    logic    peek;
    status_t res_status;
  } bfdp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;         // occupancy at or above the effective limit
    logic evict_head;
  } bfdp_sts_t;

endpackage

// ===== hw/rtl/bfdp_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bfdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bfdp_ctrl.sv =====
// request sequencer: accepts a command, decodes it against queue status
// depends on bfdp_pkg
module bfdp_ctrl import bfdp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] req_type,
  input  bfdp_sts_t sts,
  output bfdp_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  req_t   req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= req_t'(req_type);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state == S_EXEC);

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.rd         = (state == S_IDLE);
    cmd.capture    = (state == S_IDLE) && start;
    cmd.exec       = (state == S_EXEC);
    if (state == S_EXEC) begin
      unique case (req)
        REQ_ENQ: begin
          if (!sts.full) begin
            cmd.push = 1'b1;
          end else if (sts.evict_head && !sts.empty) begin
            cmd.push       = 1'b1;
            cmd.pop        = 1'b1;
            cmd.res_status = ST_DROPPED;
          end else begin
            cmd.res_status = ST_REJECT;
          end
        end
        REQ_DEQ: begin
          if (sts.empty) cmd.res_status = ST_EMPTY;
          else           cmd.pop        = 1'b1;
        end
        REQ_PEEK:  cmd.peek = !sts.empty;
        REQ_CLEAR: cmd.clr  = 1'b1;
        default:   cmd.clr  = 1'b0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bfdp_dp.sv =====
// queue datapath: ring pointers, counters, config registers, result registers
// depends on bfdp_pkg and bfdp_ram
module bfdp_dp import bfdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bfdp_cmd_t            cmd,
  output bfdp_sts_t            sts,
  input  logic [TIME_W-1:0]    time_stamp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic [1:0]           status,
  output logic [TIME_W-1:0]    head_time,
  output logic [TIME_W-1:0]    waiting_time,
  output logic [OCC_W-1:0]     occupancy,
  output logic [OCC_W-1:0]     high_water,
  output logic [TIME_W-1:0]    served_total
);

  logic              drop_policy;
  logic [SIZE_W-1:0] max_queue_size;
  logic [ADDR_W-1:0] head_ptr, head_ptr_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [CNT_W-1:0]  peak_count, peak_count_next;
  logic [TIME_W-1:0] served_counter, served_counter_next;
  logic [TIME_W-1:0] req_time;
  logic [TIME_W-1:0] head_data;
  logic [LIM_W-1:0]  limit;
  logic [CNT_W:0]    wsum;
  logic [ADDR_W-1:0] waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_policy    <= 1'b0;
      max_queue_size <= MAX_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DROP_POLICY: drop_policy    <= cfg_data[0];
        CFG_MAX_SIZE:    max_queue_size <= cfg_data;
        default:         drop_policy    <= drop_policy;
      endcase
    end
  end

  // effective limit saturates at the ring depth
  assign limit = (LIM_W'(max_queue_size) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                           : LIM_W'(max_queue_size);

  assign sts.empty      = (entry_count == '0);
  assign sts.full       = (LIM_W'(entry_count) >= limit);
  assign sts.evict_head = drop_policy;

  // tail slot, wrapped into the ring
  assign wsum  = (CNT_W+1)'(head_ptr) + (CNT_W+1)'(entry_count);
  assign waddr = (wsum >= (CNT_W+1)'(DEPTH)) ? ADDR_W'(wsum - (CNT_W+1)'(DEPTH))
                                             : ADDR_W'(wsum);

  always_comb begin
    head_ptr_next       = head_ptr;
    entry_count_next    = entry_count + CNT_W'(cmd.push) - CNT_W'(cmd.pop);
    served_counter_next = served_counter + TIME_W'(cmd.pop);
    if (cmd.pop) begin
      head_ptr_next = (head_ptr == ADDR_W'(DEPTH - 1)) ? '0 : head_ptr + ADDR_W'(1);
    end
    peak_count_next = (entry_count_next > peak_count) ? entry_count_next : peak_count;
    if (cmd.clr) begin
      head_ptr_next       = '0;
      entry_count_next    = '0;
      peak_count_next     = '0;
      served_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr       <= '0;
      entry_count    <= '0;
      peak_count     <= '0;
      served_counter <= '0;
    end else if (cmd.exec) begin
      head_ptr       <= head_ptr_next;
      entry_count    <= entry_count_next;
      peak_count     <= peak_count_next;
      served_counter <= served_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_time <= time_stamp;
    end
  end

  bfdp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && cmd.push),
    .waddr (waddr),
    .wdata (req_time),
    .re    (cmd.rd),
    .raddr (head_ptr),
    .rdata (head_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= cmd.res_status;
      head_time    <= cmd.pop  ? head_data : '0;
      waiting_time <= cmd.peek ? (req_time - head_data) : '0;
      occupancy    <= OCC_W'(entry_count_next);
      high_water   <= OCC_W'(peak_count_next);
      served_total <= served_counter_next;
    end
  end

endmodule

// ===== hw/rtl/bounded_fifo_with_discard_policy.sv =====
// top level of the bounded timestamp fifo with drop-tail / drop-oldest policy
// depends on bfdp_pkg, bfdp_ctrl, bfdp_dp (and bfdp_ram below it)
//
// A request (req_type, time_stamp) is taken when start is high and busy is low.
// Each request yields exactly one result, presented for a single cycle with
// done high; the receiver cannot stall, so it must capture the result in that
// cycle. A request passes through the accept (idle) state, in which the head
// entry is read into the storage ram's output register, and then the execute
// state, in which counters, pointers and the ram write update. The result
// shows in the cycle after execute, and busy is already low then, so a new
// request may be accepted while the previous result is on the ports, but not
// while one is in execute. The single read port of the timestamp ram with its
// registered output is why the head entry is read ahead in the accept state.
// Configuration writes use cfg_valid/cfg_ready (ready is always high) and
// should only be issued when no request is in flight. The timestamp ram has
// no reset; only data from slots that hold queued entries is ever used.
module bounded_fifo_with_discard_policy import bfdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [TIME_W-1:0]    time_stamp,
  // result channel
  output logic                 done,
  output logic [1:0]           status,
  output logic [TIME_W-1:0]    head_time,
  output logic [TIME_W-1:0]    waiting_time,
  output logic [OCC_W-1:0]     occupancy,
  output logic [OCC_W-1:0]     high_water,
  output logic [TIME_W-1:0]    served_total,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  bfdp_cmd_t cmd;
  bfdp_sts_t sts;

  // config registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle/execute, decodes the request against queue status
  bfdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  // ring buffer, counters and result registers
  bfdp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .time_stamp   (time_stamp),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .head_time    (head_time),
    .waiting_time (waiting_time),
    .occupancy    (occupancy),
    .high_water   (high_water),
    .served_total (served_total)
  );

  // an accepted request enters execute, then returns to idle with its result
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy ##1 (!busy && done)))
    else $error("request did not complete in two cycles");

  // a result never coincides with a request in execution
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // push and pop only happen in the execute cycle, never with clear
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.pop || cmd.clr) |-> (cmd.exec && !(cmd.clr && (cmd.push || cmd.pop))))
    else $error("queue update outside execute or mixed with clear");

  // reported occupancy never exceeds the high-water mark
  a_hw: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= high_water))
    else $error("occupancy above high water");

endmodule

// ===== dv/tb_bounded_fifo_with_discard_policy.sv =====
// self-checking testbench for bounded_fifo_with_discard_policy: directed corner cases,
// then random request mixes under both discard policies and several size limits
// depends on bfdp_pkg and the rtl of the bounded timestamp fifo
package tb_bfdp_check_pkg;
  import bfdp_pkg::*;

  // one expected response of the fifo
  typedef struct packed {
    status_t           status;
    logic [TIME_W-1:0] head_time;
    logic [TIME_W-1:0] waiting_time;
    logic [OCC_W-1:0]  occupancy;
    logic [OCC_W-1:0]  high_water;
    logic [TIME_W-1:0] served_total;
  } fifo_reply_t;

  // shadow copy of the timestamp ring, its counters and registers
  class stamp_fifo_shadow;
    logic [TIME_W-1:0] stamp_mem [DEPTH];
    int unsigned       head_idx;
    int unsigned       held;
    int unsigned       peak;
    logic [TIME_W-1:0] served;
    logic              evict_oldest;
    logic [SIZE_W-1:0] size_limit;
    fifo_reply_t       pending_replies[$];
    int unsigned       mismatches;

    function new();
      head_idx     = 0;
      held         = 0;
      peak         = 0;
      served       = '0;
      evict_oldest = 1'b0;
      size_limit   = MAX_SIZE_RST;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [SIZE_W-1:0] data);
      case (idx)
        CFG_DROP_POLICY: evict_oldest = data[0];
        CFG_MAX_SIZE:    size_limit = data;
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] pop_oldest();
      logic [TIME_W-1:0] t;
      t        = stamp_mem[head_idx];
      head_idx = (head_idx + 1) % DEPTH;
      held--;
      served++;
      return t;
    endfunction

    // work out the reply to an accepted request and queue it
    function void take_request(req_t req, logic [TIME_W-1:0] stamp);
      fifo_reply_t r;
      int unsigned lim;
      bit          keep;
      r        = '0;
      r.status = ST_OK;
      keep     = 1'b1;
      lim      = (size_limit > DEPTH) ? DEPTH : size_limit;
      case (req)
        REQ_ENQ: begin
          if (held >= lim) begin
            if (!evict_oldest || held == 0) begin
              r.status = ST_REJECT;
              keep     = 1'b0;
            end else begin
              r.head_time = pop_oldest();
              r.status    = ST_DROPPED;
            end
          end
          if (keep) begin
            stamp_mem[(head_idx + held) % DEPTH] = stamp;
            held++;
            if (held > peak) peak = held;
          end
        end
        REQ_DEQ: begin
          if (held == 0) r.status = ST_EMPTY;
          else r.head_time = pop_oldest();
        end
        REQ_PEEK: begin
          if (held != 0) r.waiting_time = stamp - stamp_mem[head_idx];
        end
        default: begin
          head_idx = 0;
          held     = 0;
          peak     = 0;
          served   = '0;
        end
      endcase
      r.occupancy    = OCC_W'(held);
      r.high_water   = OCC_W'(peak);
      r.served_total = served;
      pending_replies = {pending_replies, r};
    endfunction

    function void check_result(fifo_reply_t got);
      fifo_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with no request outstanding", $realtime);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.head_time !== want.head_time ||
          got.waiting_time !== want.waiting_time || got.occupancy !== want.occupancy ||
          got.high_water !== want.high_water || got.served_total !== want.served_total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: response mismatch", $realtime);
          $display("  status exp %0d got %0d, head_time exp %h got %h",
                   want.status, got.status, want.head_time, got.head_time);
          $display("  waiting_time exp %h got %h, occupancy exp %0d got %0d",
                   want.waiting_time, got.waiting_time, want.occupancy, got.occupancy);
          $display("  high_water exp %0d got %0d, served_total exp %h got %h",
                   want.high_water, got.high_water, want.served_total, got.served_total);
        end
      end
    endfunction
  endclass
endpackage

module tb_bounded_fifo_with_discard_policy;
  timeunit 1ns;
  timeprecision 1ps;
  import bfdp_pkg::*;
  import tb_bfdp_check_pkg::*;

  // cycles with no transfer at all before the run is declared hung
  localparam int STALL_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_type;
  logic [TIME_W-1:0]    time_stamp;
  logic                 done;
  logic [1:0]           status;
  logic [TIME_W-1:0]    head_time;
  logic [TIME_W-1:0]    waiting_time;
  logic [OCC_W-1:0]     occupancy;
  logic [OCC_W-1:0]     high_water;
  logic [TIME_W-1:0]    served_total;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  stamp_fifo_shadow shadow = new();
  int unsigned      quiet_cycles = 0;

  always #10 clk = ~clk;

  bounded_fifo_with_discard_policy u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .time_stamp   (time_stamp),
    .done         (done),
    .status       (status),
    .head_time    (head_time),
    .waiting_time (waiting_time),
    .occupancy    (occupancy),
    .high_water   (high_water),
    .served_total (served_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // monitor: every value read here is the one from before the edge, so
  // request, response and register transfers are seen exactly as the dut sees them
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        shadow.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (start && !busy)
        shadow.take_request(req_t'(req_type), time_stamp);
      if (done)
        shadow.check_result({status_t'(status), head_time, waiting_time,
                             occupancy, high_water, served_total});
      // watchdog on cycles with no transfer of any kind
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one request and return at the edge that takes it;
  // start stays high so back-to-back requests need no extra assignment
  task automatic send_req(req_t req, logic [TIME_W-1:0] stamp);
    start      <= 1'b1;
    req_type   <= req;
    time_stamp <= stamp;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending and let every outstanding response come back, plus a
  // margin for the request pipeline
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // registers only change with the fifo idle; upper policy bits are noise
  task automatic set_policy(bit oldest, logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] pol_word;
    pol_word    = SIZE_W'($urandom);
    pol_word[0] = oldest;
    wait_drained();
    cfg_write(CFG_DROP_POLICY, pol_word);
    cfg_write(CFG_MAX_SIZE, size);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random requests drawn from the given weights
  task automatic run_mix(int unsigned count, int unsigned w_enq, int unsigned w_deq,
                         int unsigned w_peek, int unsigned w_clr, int unsigned idle_pct);
    int unsigned pick;
    req_t        req;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(1, w_enq + w_deq + w_peek + w_clr);
      if (pick <= w_enq) req = REQ_ENQ;
      else if (pick <= w_enq + w_deq) req = REQ_DEQ;
      else if (pick <= w_enq + w_deq + w_peek) req = REQ_PEEK;
      else req = REQ_CLEAR;
      send_req(req, pick_stamp());
      if ($urandom_range(1, 100) <= idle_pct)
        hold_off($urandom_range(1, 3));
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] size;
    rst        <= 1'b1;
    start      <= 1'b0;
    req_type   <= REQ_ENQ;
    time_stamp <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_DROP_POLICY;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty fifo, wrap of the waiting time, extreme stamps
    send_req(REQ_DEQ, 32'h0000_0000);
    send_req(REQ_PEEK, 32'hFFFF_FFFF);
    send_req(REQ_CLEAR, 32'h0000_0000);
    send_req(REQ_ENQ, 32'h0000_0000);
    send_req(REQ_ENQ, 32'hFFFF_FFFF);
    send_req(REQ_PEEK, 32'h0000_0005);
    send_req(REQ_DEQ, 32'h0000_0000);
    hold_off(1);
    send_req(REQ_PEEK, 32'h0000_0003);
    send_req(REQ_DEQ, 32'h0000_0000);
    send_req(REQ_DEQ, 32'h0000_0000);
    send_req(REQ_ENQ, 32'hAAAA_AAAA);
    hold_off(2);
    send_req(REQ_ENQ, 32'h5555_5555);
    send_req(REQ_ENQ, 32'h1234_5678);

    // limit lowered below occupancy: drop tail rejects, drop oldest swaps
    set_policy(1'b0, 11'd2);
    send_req(REQ_ENQ, 32'h0BAD_0001);
    set_policy(1'b1, 11'd2);
    send_req(REQ_ENQ, 32'h0BAD_0002);
    send_req(REQ_PEEK, $urandom);

    // limit of zero: eviction while entries remain, rejection once empty
    set_policy(1'b1, 11'd0);
    send_req(REQ_ENQ, 32'h0BAD_0003);
    send_req(REQ_CLEAR, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, 32'h0BAD_0004);
    set_policy(1'b0, 11'd0);
    send_req(REQ_ENQ, 32'h0BAD_0005);

    // limit of one, then a limit above the ring depth
    set_policy(1'b0, 11'd1);
    send_req(REQ_ENQ, 32'h8000_0000);
    send_req(REQ_ENQ, 32'h7FFF_FFFF);
    set_policy(1'b1, 11'h7FF);
    send_req(REQ_ENQ, $urandom);
    send_req(REQ_DEQ, $urandom);
    send_req(REQ_CLEAR, $urandom);

    // fill the whole ring so the write slot wraps and drop oldest fires at
    // full depth; the middle stretch runs with no idling at all
    run_mix(450, 95, 0, 5, 0, 20);
    run_mix(500, 95, 0, 5, 0, 0);
    run_mix(200, 95, 0, 5, 0, 20);

    // full ring under drop tail: rejects at the maximum occupancy
    set_policy(1'b0, MAX_SIZE_RST);
    run_mix(100, 70, 10, 20, 0, 20);

    // small and random limits with the full request mix
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       size = 11'd1;
        1:       size = 11'd2;
        2:       size = 11'd3;
        3:       size = SIZE_W'($urandom_range(4, 16));
        4:       size = SIZE_W'($urandom_range(17, 2047));
        default: size = SIZE_W'($urandom_range(4, 40));
      endcase
      set_policy(bit'($urandom_range(0, 1)), size);
      run_mix(90, 45, 30, 15, 10, 20);
    end

    wait_drained();
    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bfdp_pkg.sv
hw/rtl/bfdp_ram.sv
hw/rtl/bfdp_ctrl.sv
hw/rtl/bfdp_dp.sv
hw/rtl/bounded_fifo_with_discard_policy.sv
dv/tb_bounded_fifo_with_discard_policy.sv
